// ===== design/plen_pkg.sv =====
// ----------------------------------------------------------------------------
// plen_pkg
// Shared types and constants for the positional list engine: sizes, operation
// and status codes, controller states and the store access struct.
// ----------------------------------------------------------------------------
package plen_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int COUNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W       = 5;
  localparam int KIND_W      = 3;
  localparam int OUT_W       = 32;
  localparam int CMP_W       = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  typedef enum logic [KIND_W-1:0] {
    K_SET    = 3'd0,
    K_GET    = 3'd1,
    K_INSERT = 3'd2,
    K_REMOVE = 3'd3,
    K_FRONT  = 3'd4,
    K_BACK   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GET_WAIT,
    S_HOLD_WAIT,
    S_SHIFT,
    S_FINISH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
  } mem_req_t;

endpackage

// ===== design/plen_store.sv =====
// ----------------------------------------------------------------------------
// plen_store
// Entry memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module plen_store (
  input  logic                               clk,
  input  plen_pkg::mem_req_t                 req,
  output logic [plen_pkg::VALUE_WIDTH-1:0]   rd_data
);

  logic [plen_pkg::VALUE_WIDTH-1:0] mem [plen_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== design/plen_ctrl.sv =====
// ----------------------------------------------------------------------------
// plen_ctrl
// Request sequencer: checks each request against the count, then reads,
// shifts entries one place per cycle through the store and writes back.
// ----------------------------------------------------------------------------
module plen_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [plen_pkg::KIND_W-1:0]         kind,
  input  logic [plen_pkg::POS_W-1:0]          position,
  input  logic [plen_pkg::OUT_W-1:0]          value,
  output logic                                busy,
  output logic                                done,
  output logic [plen_pkg::VALUE_WIDTH-1:0]    rd_value,
  output plen_pkg::status_t                   status_r,
  output logic [plen_pkg::COUNT_W-1:0]        cnt,
  output plen_pkg::mem_req_t                  mem_req,
  input  logic [plen_pkg::VALUE_WIDTH-1:0]    rd_data
);

  plen_pkg::state_t                 state, state_next;
  plen_pkg::kind_t                  req_kind;
  logic [plen_pkg::CMP_W-1:0]       req_pos;
  logic [plen_pkg::VALUE_WIDTH-1:0] req_val;
  logic [plen_pkg::VALUE_WIDTH-1:0] hold;
  logic [plen_pkg::ADDR_W-1:0]      rd_ptr, wr_ptr, fin_addr;
  logic [plen_pkg::COUNT_W-1:0]     rd_left;
  logic                             pend, up, fin_en;

  logic [plen_pkg::CMP_W-1:0]       pc, cc, last;
  logic [plen_pkg::ADDR_W-1:0]      pa;
  logic                             in_range, at_last, accept;
  plen_pkg::status_t                dec_status;

  assign pc       = req_pos;
  assign cc       = plen_pkg::CMP_W'(cnt);
  assign last     = cc - plen_pkg::CMP_W'(1);
  assign pa       = plen_pkg::ADDR_W'(req_pos);
  assign in_range = pc < cc;
  assign at_last  = (cc != '0) && (pc == last);
  assign accept   = start && !busy;

  always_comb begin
    dec_status = plen_pkg::ST_OK;
    case (req_kind)
      plen_pkg::K_SET, plen_pkg::K_GET: begin
        if (!in_range) dec_status = plen_pkg::ST_BAD;
      end
      plen_pkg::K_INSERT: begin
        if (pc > cc) dec_status = plen_pkg::ST_BAD;
        else if (cc >= plen_pkg::CMP_W'(plen_pkg::CAPACITY)) dec_status = plen_pkg::ST_FULL;
      end
      plen_pkg::K_REMOVE: begin
        if (pc == '0 && cc == '0) dec_status = plen_pkg::ST_EMPTY;
        else if (!in_range) dec_status = plen_pkg::ST_BAD;
      end
      plen_pkg::K_FRONT: begin
        if (pc != '0 && !in_range) dec_status = plen_pkg::ST_BAD;
      end
      plen_pkg::K_BACK: begin
        if (!at_last && !in_range) dec_status = plen_pkg::ST_BAD;
      end
      default: dec_status = plen_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plen_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    mem_req    = '0;
    case (state)
      plen_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) state_next = plen_pkg::S_DECODE;
      end
      plen_pkg::S_DECODE: begin
        state_next = plen_pkg::S_RESULT;
        case (req_kind)
          plen_pkg::K_SET: begin
            if (in_range) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = pa;
              mem_req.wr_data = req_val;
            end
          end
          plen_pkg::K_GET: begin
            if (in_range) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = pa;
              state_next      = plen_pkg::S_GET_WAIT;
            end
          end
          plen_pkg::K_INSERT: begin
            if (dec_status == plen_pkg::ST_OK) begin
              if (pc == cc) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pa;
                mem_req.wr_data = req_val;
              end else begin
                state_next = plen_pkg::S_SHIFT;
              end
            end
          end
          plen_pkg::K_REMOVE: begin
            if (in_range && !at_last) state_next = plen_pkg::S_SHIFT;
          end
          plen_pkg::K_FRONT: begin
            if (pc != '0 && in_range) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = pa;
              state_next      = plen_pkg::S_HOLD_WAIT;
            end
          end
          plen_pkg::K_BACK: begin
            if (!at_last && in_range) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = pa;
              state_next      = plen_pkg::S_HOLD_WAIT;
            end
          end
          default: state_next = plen_pkg::S_RESULT;
        endcase
      end
      plen_pkg::S_GET_WAIT: begin
        state_next = plen_pkg::S_RESULT;
      end
      plen_pkg::S_HOLD_WAIT: begin
        state_next = plen_pkg::S_SHIFT;
      end
      plen_pkg::S_SHIFT: begin
        if (rd_left != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_ptr;
        end else begin
          state_next = plen_pkg::S_FINISH;
        end
        if (pend) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = wr_ptr;
          mem_req.wr_data = rd_data;
        end
      end
      plen_pkg::S_FINISH: begin
        if (fin_en) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = fin_addr;
          mem_req.wr_data = hold;
        end
        state_next = plen_pkg::S_RESULT;
      end
      plen_pkg::S_RESULT: begin
        busy = 1'b0;
        done = 1'b1;
        state_next = start ? plen_pkg::S_DECODE : plen_pkg::S_IDLE;
      end
      default: state_next = plen_pkg::S_IDLE;
    endcase
  end

  // count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == plen_pkg::S_DECODE && dec_status == plen_pkg::ST_OK) begin
      if (req_kind == plen_pkg::K_INSERT) begin
        cnt <= cnt + plen_pkg::COUNT_W'(1);
      end else if (req_kind == plen_pkg::K_REMOVE) begin
        cnt <= cnt - plen_pkg::COUNT_W'(1);
      end
    end
  end

  // request capture and shift datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= plen_pkg::kind_t'(kind);
      req_pos  <= plen_pkg::CMP_W'(position);
      req_val  <= value[plen_pkg::VALUE_WIDTH-1:0];
    end
    case (state)
      plen_pkg::S_DECODE: begin
        status_r <= dec_status;
        rd_value <= '0;
        pend     <= 1'b0;
        hold     <= req_val;
        case (req_kind)
          plen_pkg::K_INSERT: begin
            up       <= 1'b1;
            rd_ptr   <= plen_pkg::ADDR_W'(last);
            wr_ptr   <= plen_pkg::ADDR_W'(cc);
            rd_left  <= plen_pkg::COUNT_W'(cc - pc);
            fin_en   <= 1'b1;
            fin_addr <= pa;
          end
          plen_pkg::K_REMOVE: begin
            up      <= 1'b0;
            rd_ptr  <= pa + plen_pkg::ADDR_W'(1);
            wr_ptr  <= pa;
            rd_left <= plen_pkg::COUNT_W'(last - pc);
            fin_en  <= 1'b0;
          end
          plen_pkg::K_FRONT: begin
            up       <= 1'b1;
            rd_ptr   <= pa - plen_pkg::ADDR_W'(1);
            wr_ptr   <= pa;
            rd_left  <= plen_pkg::COUNT_W'(pc);
            fin_en   <= 1'b1;
            fin_addr <= '0;
          end
          plen_pkg::K_BACK: begin
            up       <= 1'b0;
            rd_ptr   <= pa + plen_pkg::ADDR_W'(1);
            wr_ptr   <= pa;
            rd_left  <= plen_pkg::COUNT_W'(last - pc);
            fin_en   <= 1'b1;
            fin_addr <= plen_pkg::ADDR_W'(last);
          end
          default: begin
            rd_left <= '0;
            fin_en  <= 1'b0;
          end
        endcase
      end
      plen_pkg::S_GET_WAIT: begin
        rd_value <= rd_data;
      end
      plen_pkg::S_HOLD_WAIT: begin
        hold <= rd_data;
      end
      plen_pkg::S_SHIFT: begin
        pend <= (rd_left != '0);
        if (rd_left != '0) begin
          rd_ptr  <= up ? rd_ptr - plen_pkg::ADDR_W'(1) : rd_ptr + plen_pkg::ADDR_W'(1);
          rd_left <= rd_left - plen_pkg::COUNT_W'(1);
        end
        if (pend) begin
          wr_ptr <= up ? wr_ptr - plen_pkg::ADDR_W'(1) : wr_ptr + plen_pkg::ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of up to 16 values held in a one-port-read, one-port-write
// memory, with set, get, insert, remove, move to front and move to back.
// ----------------------------------------------------------------------------
// sequence: every request passes decode then the result state; get adds a
//   read wait state, shifting requests add the shift and finish states (moves
//   also a hold read), with one memory read/write per cycle while shifting
// handshake: a new request is accepted in the done cycle; results are
//   strobed once and cannot be stalled
// reset: count cleared to zero; memory contents are left as they are
module positional_list_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  kind,
  input  logic [4:0]  position,
  input  logic [31:0] value,
  output logic        busy,
  output logic        done,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic [4:0]  count
);

  plen_pkg::mem_req_t                 mem_req;
  logic [plen_pkg::VALUE_WIDTH-1:0]   rd_data;
  logic [plen_pkg::VALUE_WIDTH-1:0]   rd_value;
  plen_pkg::status_t                  status_r;
  logic [plen_pkg::COUNT_W-1:0]       cnt;

  plen_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .position (position),
    .value    (value),
    .busy     (busy),
    .done     (done),
    .rd_value (rd_value),
    .status_r (status_r),
    .cnt      (cnt),
    .mem_req  (mem_req),
    .rd_data  (rd_data)
  );

  plen_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign read_value = 32'(rd_value);
  assign status     = status_r;
  assign count      = 5'(cnt);

endmodule

// ===== design/plen_checker.sv =====
// ----------------------------------------------------------------------------
// plen_checker
// Port-level checks on the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module plen_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] read_value,
  input logic [1:0]  status,
  input logic [4:0]  count
);

  // a result cycle also takes the next request
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy during result cycle");

  // in the cycle after an accepted request the engine is busy and not done
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("no work cycle after accepted request");

  // failed requests return no data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != plen_pkg::ST_OK) |-> (read_value == '0))
    else $error("data returned on failed request");

  // full only at capacity, empty only with no entries
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status != plen_pkg::ST_FULL || count == 5'(plen_pkg::CAPACITY)) &&
              (status != plen_pkg::ST_EMPTY || count == '0)))
    else $error("status disagrees with count");

endmodule

bind positional_list_engine_top plen_checker u_plen_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .read_value (read_value),
  .status     (status),
  .count      (count)
);

// ===== verif/positional_list_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_top_tb
// Self-checking bench for the positional list engine. Requests go in through
// the start/busy handshake and each strobed result is checked against a
// predictor that keeps its own copy of the list. A directed opening covers
// the empty, full, no-op and out-of-range cases. A long random run follows,
// weighted by the predicted fill so that the list swings between empty and
// full. Request gaps are random, with one stretch that has no gaps.
// ----------------------------------------------------------------------------
module positional_list_engine_top_tb;

  // unused kind codes, no effect on the list
  localparam logic [plen_pkg::KIND_W-1:0] K_SPARE_A = 3'd6;
  localparam logic [plen_pkg::KIND_W-1:0] K_SPARE_B = 3'd7;

  localparam int STALL_LIMIT     = 1000;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int DRAIN_CYCLES    = 30;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [plen_pkg::OUT_W-1:0] rd;
    logic [1:0]                 st;
    logic [4:0]                 cnt;
  } outcome_t;

  class list_scoreboard;
    logic [plen_pkg::VALUE_WIDTH-1:0] cells [plen_pkg::CAPACITY];
    int unsigned                      held;
    outcome_t                         awaited[$];
    int unsigned                      mismatches;
    int unsigned                      checked;
    int unsigned                      full_hits;
    int unsigned                      empty_hits;

    function logic [plen_pkg::VALUE_WIDTH-1:0] take_out(int unsigned p);
      logic [plen_pkg::VALUE_WIDTH-1:0] v;
      v = cells[p];
      for (int unsigned i = p; i + 1 < held; i++) cells[i] = cells[i + 1];
      held--;
      return v;
    endfunction

    function void put_in(int unsigned p, logic [plen_pkg::VALUE_WIDTH-1:0] v);
      for (int unsigned i = held; i > p; i--) cells[i] = cells[i - 1];
      cells[p] = v;
      held++;
    endfunction

    // predict the result of an accepted request
    function void note(logic [plen_pkg::KIND_W-1:0] op, logic [plen_pkg::POS_W-1:0] pos,
                       logic [plen_pkg::VALUE_WIDTH-1:0] val);
      outcome_t                         res;
      logic [plen_pkg::VALUE_WIDTH-1:0] moved;
      res = '0;
      res.st = plen_pkg::ST_OK;
      case (op)
        plen_pkg::K_SET: begin
          if (pos >= held) res.st = plen_pkg::ST_BAD;
          else cells[pos] = val;
        end
        plen_pkg::K_GET: begin
          if (pos >= held) res.st = plen_pkg::ST_BAD;
          else res.rd = cells[pos];
        end
        plen_pkg::K_INSERT: begin
          if (pos > held) res.st = plen_pkg::ST_BAD;
          else if (held >= plen_pkg::CAPACITY) res.st = plen_pkg::ST_FULL;
          else put_in(pos, val);
        end
        plen_pkg::K_REMOVE: begin
          if (pos == 0 && held == 0) res.st = plen_pkg::ST_EMPTY;
          else if (pos >= held) res.st = plen_pkg::ST_BAD;
          else void'(take_out(pos));
        end
        plen_pkg::K_FRONT: begin
          if (pos != 0) begin
            if (pos >= held) res.st = plen_pkg::ST_BAD;
            else begin
              moved = take_out(pos);
              put_in(0, moved);
            end
          end
        end
        plen_pkg::K_BACK: begin
          if (!(held > 0 && pos == held - 1)) begin
            if (pos >= held) res.st = plen_pkg::ST_BAD;
            else begin
              moved = take_out(pos);
              put_in(held, moved);
            end
          end
        end
        default: ;
      endcase
      res.cnt = 5'(held);
      if (res.st == plen_pkg::ST_FULL) full_hits++;
      if (res.st == plen_pkg::ST_EMPTY) empty_hits++;
      awaited.push_back(res);
    endfunction

    function void check(logic [plen_pkg::OUT_W-1:0] rd, logic [1:0] st, logic [4:0] cnt);
      outcome_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: value %h status %0d count %0d", rd, st, cnt);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.rd !== rd || want.st !== st || want.cnt !== cnt) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch %0d: expected value %h status %0d count %0d, got %h %0d %0d",
                   mismatches, want.rd, want.st, want.cnt, rd, st, cnt);
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        start    = 1'b0;
  logic [2:0]  kind     = '0;
  logic [4:0]  position = '0;
  logic [31:0] value    = '0;
  logic        busy;
  logic        done;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [4:0]  count;

  list_scoreboard sb = new();
  int unsigned    stall_cycles = 0;
  int unsigned    accepted = 0;
  bit             steady = 1'b0;

  positional_list_engine_top DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .position   (position),
    .value      (value),
    .busy       (busy),
    .done       (done),
    .read_value (read_value),
    .status     (status),
    .count      (count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done) sb.check(read_value, status, count);
      if (start && !busy) begin
        sb.note(kind, position, value);
        accepted++;
      end
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic issue(input logic [2:0] op, input logic [4:0] pos,
                       input logic [31:0] val);
    while (!steady && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    kind     <= op;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned roll;
    int unsigned ins_w;
    int unsigned rem_w;
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] val;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list corners
    issue(plen_pkg::K_REMOVE, 5'd0, 32'h0);
    issue(plen_pkg::K_REMOVE, 5'd3, 32'h0);
    issue(plen_pkg::K_FRONT, 5'd0, 32'h0);
    issue(plen_pkg::K_BACK, 5'd0, 32'h0);
    issue(plen_pkg::K_GET, 5'd0, 32'h0);
    issue(plen_pkg::K_SET, 5'd0, 32'h1234_5678);
    issue(plen_pkg::K_INSERT, 5'd1, 32'h0);
    // small list, every operation
    issue(plen_pkg::K_INSERT, 5'd0, 32'hFFFF_FFFF);
    issue(plen_pkg::K_INSERT, 5'd1, 32'h0000_0000);
    issue(plen_pkg::K_INSERT, 5'd0, 32'hA5A5_A5A5);
    issue(plen_pkg::K_GET, 5'd0, 32'h0);
    issue(plen_pkg::K_GET, 5'd2, 32'h0);
    issue(plen_pkg::K_SET, 5'd2, 32'h5A5A_5A5A);
    issue(plen_pkg::K_SET, 5'd3, 32'hDEAD_BEEF);
    issue(plen_pkg::K_FRONT, 5'd2, 32'h0);
    issue(plen_pkg::K_BACK, 5'd0, 32'h0);
    issue(plen_pkg::K_FRONT, 5'd0, 32'h0);
    issue(plen_pkg::K_BACK, 5'd2, 32'h0);
    issue(plen_pkg::K_BACK, 5'd3, 32'h0);
    issue(plen_pkg::K_GET, 5'd31, 32'h0);
    issue(K_SPARE_A, 5'd31, 32'hFFFF_FFFF);
    issue(K_SPARE_B, 5'd0, 32'h0);
    issue(plen_pkg::K_REMOVE, 5'd1, 32'h0);
    issue(plen_pkg::K_INSERT, 5'd2, 32'h8000_0001);
    // fill to capacity, then the full and out-of-range inserts and two removes
    while (sb.held < plen_pkg::CAPACITY)
      issue(plen_pkg::K_INSERT, 5'($urandom_range(0, sb.held)), $urandom);
    issue(plen_pkg::K_INSERT, 5'd0, 32'h0);
    issue(plen_pkg::K_INSERT, 5'd17, 32'h0);
    issue(plen_pkg::K_REMOVE, 5'd15, 32'h0);
    issue(plen_pkg::K_REMOVE, 5'd0, 32'h0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 600 && n < 900);
      ins_w = (sb.held < 4) ? 45 : (sb.held > 12) ? 15 : 28;
      rem_w = (sb.held < 4) ? 12 : (sb.held > 12) ? 40 : 25;
      roll = $urandom_range(0, 99);
      if (roll < ins_w) op = plen_pkg::K_INSERT;
      else if (roll < ins_w + rem_w) op = plen_pkg::K_REMOVE;
      else if (roll >= 97) op = roll[0] ? K_SPARE_A : K_SPARE_B;
      else begin
        case ($urandom_range(0, 3))
          0:       op = plen_pkg::K_SET;
          1:       op = plen_pkg::K_GET;
          2:       op = plen_pkg::K_FRONT;
          default: op = plen_pkg::K_BACK;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        if (op == plen_pkg::K_INSERT) pos = 5'($urandom_range(0, sb.held));
        else if (sb.held == 0) pos = '0;
        else pos = 5'($urandom_range(0, sb.held - 1));
      end else if (roll < 90) begin
        pos = 5'(sb.held + $urandom_range(0, 1));
      end else begin
        pos = 5'($urandom_range(0, 31));
      end
      roll = $urandom_range(0, 19);
      if (roll == 0) val = '0;
      else if (roll == 1) val = '1;
      else val = $urandom;
      issue(op, pos, val);
    end
    start <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d checked results, %0d mismatches",
             accepted, sb.checked, sb.mismatches);
    $display("full store rejected %0d inserts, empty list rejected %0d removes",
             sb.full_hits, sb.empty_hits);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/plen_pkg.sv
design/plen_store.sv
design/plen_ctrl.sv
design/positional_list_engine_top.sv
design/plen_checker.sv
verif/positional_list_engine_top_tb.sv
